>>> hw/rtl/sut_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted unique insert table: shared types
// Transaction payloads, the stored entry layout and the result status codes.
// ----------------------------------------------------------------------------
package sut_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Input transaction.
  typedef struct packed {
    logic [31:0] stamp_key;
    logic [7:0]  server_key;
    logic [15:0] payload_ref;
  } item_t;

  // Result transaction.
  typedef struct packed {
    status_e     status;
    logic [6:0]  position;
    logic [6:0]  count_after;
  } result_t;

  // One stored table entry.
  typedef struct packed {
    logic [31:0] stamp;
    logic [7:0]  server;
    logic [15:0] payload;
  } entry_t;

endpackage

>>> hw/rtl/sut_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted unique insert table: entry store
// Single write port and single read port memory with registered read data.
// ----------------------------------------------------------------------------
module sut_store import sut_pkg::*; #(
  parameter int unsigned Entries = 64,
  parameter int unsigned AddrW   = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [Entries];
  entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data appears the cycle after the address.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sorted_unique_insert_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted unique insert table
// Keeps entries sorted by (time stamp, server id), rejects duplicate keys and
// reports where each transaction landed. One memory port pair is stepped by a
// small sequencer: a linear scan, then a shift of the later entries by one.
// ----------------------------------------------------------------------------
// Sequence: an inserted result strobes after the scan, any shift of the later
//   entries and the write of the new entry; a duplicate or full result
//   strobes after the scan, with nothing written.
// Throughput: one transaction at a time, set by the single read port of the
//   store, which is visited once per scanned and once per shifted entry. The
//   next transaction can be accepted in the same cycle that the strobe shows.
// Reset: the entry count and the order bit clear to zero; the store itself
//   is not cleared, as only entries below the count are ever used.
// The result strobe lasts one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module sorted_unique_insert_table_top import sut_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  input  logic    cfg_we_i,
  input  logic    cfg_wdata_i,
  output logic    done_o,
  output result_t res_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_WRITE_NEW
  } state_e;

  state_e         state_q;
  logic           order_q;
  logic [CW-1:0]  count_q;
  logic [CW-1:0]  pos_q;
  logic           dup_q;
  logic [IW-1:0]  scan_idx_q;
  logic [IW-1:0]  sh_idx_q;
  item_t          item_q;
  logic           done_q;
  result_t        res_q;

  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  entry_t         mem_wdata;
  logic [IW-1:0]  mem_raddr;
  entry_t         mem_rdata;

  logic [CW-1:0]  scan_next;
  logic [CW-1:0]  count_m1;
  logic           key_gt;
  logic           key_eq;
  logic           goes_first;
  logic           sh_last;

  // Key compare against the entry just read.
  assign key_gt = {item_q.stamp_key, item_q.server_key} >
                  {mem_rdata.stamp, mem_rdata.server};
  assign key_eq = {item_q.stamp_key, item_q.server_key} ==
                  {mem_rdata.stamp, mem_rdata.server};
  assign goes_first = order_q ? (!key_gt && !key_eq) : key_gt;

  assign scan_next = CW'(scan_idx_q) + CW'(1);
  assign count_m1  = count_q - CW'(1);
  assign sh_last   = (CW'(sh_idx_q) == (pos_q + CW'(1)));

  // Memory port control per sequencer step.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sh_idx_q;
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    unique case (state_q)
      S_IDLE: begin
        mem_raddr = '0;
      end
      S_SCAN: begin
        mem_raddr = scan_next[IW-1:0];
      end
      S_DECIDE: begin
        mem_raddr = count_m1[IW-1:0];
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = sh_idx_q;
        mem_wdata = mem_rdata;
        mem_raddr = sh_idx_q - IW'(2);
      end
      S_WRITE_NEW: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[IW-1:0];
        mem_wdata = '{stamp:   item_q.stamp_key,
                      server:  item_q.server_key,
                      payload: item_q.payload_ref};
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  sut_store #(
    .Entries (ENTRIES),
    .AddrW   (IW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer with its registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      order_q    <= 1'b0;
      count_q    <= '0;
      pos_q      <= '0;
      dup_q      <= 1'b0;
      scan_idx_q <= '0;
      sh_idx_q   <= '0;
      item_q     <= '0;
      done_q     <= 1'b0;
      res_q      <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            item_q     <= item_i;
            dup_q      <= 1'b0;
            scan_idx_q <= '0;
            if (count_q == '0) begin
              pos_q   <= '0;
              state_q <= S_DECIDE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // The new key goes ahead of this entry, matches it, or the scan ends.
          priority if (goes_first) begin
            pos_q   <= CW'(scan_idx_q);
            state_q <= S_DECIDE;
          end else if (key_eq) begin
            pos_q   <= CW'(scan_idx_q);
            dup_q   <= 1'b1;
            state_q <= S_DECIDE;
          end else if (scan_next == count_q) begin
            pos_q   <= count_q;
            state_q <= S_DECIDE;
          end else begin
            scan_idx_q <= scan_next[IW-1:0];
          end
        end
        S_DECIDE: begin
          priority if (dup_q) begin
            res_q.status      <= ST_DUPLICATE;
            res_q.position    <= 7'(pos_q);
            res_q.count_after <= 7'(count_q);
            done_q            <= 1'b1;
            state_q           <= S_IDLE;
          end else if (count_q == CW'(ENTRIES)) begin
            res_q.status      <= ST_FULL;
            res_q.position    <= 7'(pos_q);
            res_q.count_after <= 7'(count_q);
            done_q            <= 1'b1;
            state_q           <= S_IDLE;
          end else if (pos_q == count_q) begin
            state_q <= S_WRITE_NEW;
          end else begin
            sh_idx_q <= count_q[IW-1:0];
            state_q  <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // One entry moves up per cycle, from the end down to the gap.
          if (sh_last) begin
            state_q <= S_WRITE_NEW;
          end else begin
            sh_idx_q <= sh_idx_q - IW'(1);
          end
        end
        S_WRITE_NEW: begin
          count_q           <= count_q + CW'(1);
          res_q.status      <= ST_INSERTED;
          res_q.position    <= 7'(pos_q);
          res_q.count_after <= 7'(count_q + CW'(1));
          done_q            <= 1'b1;
          state_q           <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // The table never holds more entries than it has room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("entry count exceeds table size");

  // An accepted transaction makes the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start the sequencer");

  // The count only moves together with an inserted result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (done_o && res_o.status == ST_INSERTED))
    else $error("entry count changed without an insertion");

  // A result is shown only once the sequencer has returned to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == S_IDLE))
    else $error("result strobe outside idle");

endmodule
